### rtl/efd_pkg.sv
`default_nettype none
package efd_pkg;

  localparam int unsigned HeaderSize = 4;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_TRUNC_HEADER  = 2'd0;
  localparam logic [1:0] ERR_TOO_LARGE     = 2'd1;
  localparam logic [1:0] ERR_TRUNC_PAYLOAD = 2'd2;

  localparam logic [1:0] REG_ID_MASK      = 2'd0;
  localparam logic [1:0] REG_REPLACE_MASK = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;

  localparam logic [15:0] ID_MASK_RST      = 16'h7fff;
  localparam logic [15:0] REPLACE_MASK_RST = 16'h8000;
  localparam logic [7:0]  MAX_PAYLOAD_RST  = 8'hff;

  typedef struct packed {
    logic [15:0] id_mask;
    logic [15:0] replace_mask;
    logic [7:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] event_id;
    logic        replacement;
    logic [7:0]  source_id;
    logic [7:0]  payload_len;
    logic [8:0]  consumed;
    logic [1:0]  error_code;
    logic        run_end;
  } res_t;

  function automatic res_t make_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.kind = KIND_BYTE;
    r.payload_byte = b;
    return r;
  endfunction

  function automatic res_t make_done(input logic [15:0] hdr, input cfg_t cfg,
                                     input logic [7:0] src, input logic [7:0] len);
    res_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.event_id = hdr & cfg.id_mask;
    r.replacement = |(hdr & cfg.replace_mask);
    r.source_id = src;
    r.payload_len = len;
    r.consumed = 9'(HeaderSize) + {1'b0, len};
    return r;
  endfunction

  function automatic res_t make_error(input logic [1:0] code);
    res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/efd_if.sv
`default_nettype none
interface efd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, data_byte, buffer_end, input ready);
  modport sink (input valid, data_byte, buffer_end, output ready);
endinterface

interface efd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] event_id;
  logic        replacement;
  logic [7:0]  source_id;
  logic [7:0]  payload_len;
  logic [8:0]  consumed;
  logic [1:0]  error_code;
  logic        run_end;

  modport source (output valid, kind, payload_byte, event_id, replacement, source_id,
                  payload_len, consumed, error_code, run_end, input ready);
  modport sink (input valid, kind, payload_byte, event_id, replacement, source_id,
                payload_len, consumed, error_code, run_end, output ready);
endinterface
`default_nettype wire

### rtl/efd_decode.sv
`default_nettype none
module efd_decode
  import efd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] data_byte,
  input  wire logic       buffer_end,
  input  wire cfg_t       cfg,
  output logic [1:0]      n_res,
  output res_t            res0,
  output res_t            res1
);

  localparam logic [2:0] PH_HDR_LO  = 3'd0;
  localparam logic [2:0] PH_HDR_HI  = 3'd1;
  localparam logic [2:0] PH_SOURCE  = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] header_r, header_nxt;
  logic [7:0]  source_r, source_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  left_dec;

  assign left_dec = left_r - 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    source_nxt = source_r;
    length_nxt = length_r;
    left_nxt   = left_r;
    n_res      = 2'd0;
    res0       = '0;
    res1       = '0;
    unique case (phase_r)
      PH_HDR_LO: begin
        header_nxt = {8'h00, data_byte};
        if (buffer_end) begin
          res0  = make_error(ERR_TRUNC_HEADER);
          n_res = 2'd1;
        end else begin
          phase_nxt = PH_HDR_HI;
        end
      end
      PH_HDR_HI: begin
        header_nxt = {data_byte, header_r[7:0]};
        if (buffer_end) begin
          res0      = make_error(ERR_TRUNC_HEADER);
          n_res     = 2'd1;
          phase_nxt = PH_HDR_LO;
        end else begin
          phase_nxt = PH_SOURCE;
        end
      end
      PH_SOURCE: begin
        source_nxt = data_byte;
        if (buffer_end) begin
          res0      = make_error(ERR_TRUNC_HEADER);
          n_res     = 2'd1;
          phase_nxt = PH_HDR_LO;
        end else begin
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        length_nxt = data_byte;
        if (data_byte > cfg.max_payload) begin
          res0      = make_error(ERR_TOO_LARGE);
          n_res     = 2'd1;
          phase_nxt = buffer_end ? PH_HDR_LO : PH_SKIP;
        end else if (data_byte == 8'd0) begin
          res0      = make_done(header_r, cfg, source_r, data_byte);
          n_res     = 2'd1;
          phase_nxt = buffer_end ? PH_HDR_LO : PH_SKIP;
        end else if (buffer_end) begin
          res0      = make_error(ERR_TRUNC_PAYLOAD);
          n_res     = 2'd1;
          phase_nxt = PH_HDR_LO;
        end else begin
          left_nxt  = data_byte;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res0     = make_byte(data_byte);
        n_res    = 2'd1;
        left_nxt = left_dec;
        if (left_dec == 8'd0) begin
          res1      = make_done(header_r, cfg, source_r, length_r);
          n_res     = 2'd2;
          phase_nxt = buffer_end ? PH_HDR_LO : PH_SKIP;
        end else if (buffer_end) begin
          res1      = make_error(ERR_TRUNC_PAYLOAD);
          n_res     = 2'd2;
          left_nxt  = 8'd0;
          phase_nxt = PH_HDR_LO;
        end
      end
      default: begin
        // trailing bytes after a finished frame
        phase_nxt = buffer_end ? PH_HDR_LO : PH_SKIP;
      end
    endcase
    if (n_res == 2'd1) res0.run_end = 1'b1;
    if (n_res == 2'd2) res1.run_end = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR_LO;
      header_r <= '0;
      source_r <= '0;
      length_r <= '0;
      left_r   <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      source_r <= source_nxt;
      length_r <= length_nxt;
      left_r   <= left_nxt;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (!rst_n)
    acc && buffer_end |=> phase_r == PH_HDR_LO)
    else $error("phase not back at header after buffer end");
  assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_PAYLOAD |-> n_res != 2'd0)
    else $error("payload word produced no result");
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != 8'd0)
    else $error("payload phase with no bytes left");
`endif

endmodule
`default_nettype wire

### rtl/efd_outq.sv
`default_nettype none
module efd_outq
  import efd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [1:0] n_res,
  input  wire res_t       res0,
  input  wire res_t       res1,
  output logic            can_take,
  output logic            head_valid,
  input  wire logic       head_ready,
  output res_t            head
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_left;
  res_t       s0_r, s0_nxt;
  res_t       s1_r, s1_nxt;
  logic       pop;

  assign head_valid = cnt_r != 2'd0;
  assign head       = s0_r;
  assign pop        = head_valid && head_ready;
  assign cnt_left   = cnt_r - {1'b0, pop};
  // a word may bring two results, so both slots must be free after this pop
  assign can_take   = cnt_left == 2'd0;

  always_comb begin
    cnt_nxt = cnt_left;
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    if (push) begin
      s0_nxt  = res0;
      s1_nxt  = res1;
      cnt_nxt = n_res;
    end else if (pop) begin
      s0_nxt = s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_left == 2'd0)
    else $error("push into occupied result slots");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && pop |=> cnt_r == 2'd1 && s0_r == $past(s1_r))
    else $error("second slot not promoted");
`endif

endmodule
`default_nettype wire

### rtl/event_frame_deframer.sv
`default_nettype none
// channel   dir  handshake        payload
// in_ch     in   valid / ready    data_byte, buffer_end
// out_ch    out  valid / ready    kind, payload_byte, event_id, replacement, source_id,
//                                 payload_len, consumed, error_code, run_end
// cfg_*     in   cfg_we only      cfg_index, cfg_data
//
// one word per cycle unless stalled; results leave a two-slot queue one per cycle
// while out_ch.ready is high. a two-result word (last payload byte plus done or
// error) stalls in_ch until both leave; in_ch.ready is high when both slots are
// free after this cycle's pop. the first result is valid in the cycle after accept.
// synchronous active-low reset clears frame state and queue count and presets config.
module event_frame_deframer
  import efd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  efd_in_if.sink           in_ch,
  efd_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t       cfg_r;
  logic       acc;
  logic       can_take;
  logic [1:0] n_res;
  res_t       res0, res1, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.id_mask      <= ID_MASK_RST;
      cfg_r.replace_mask <= REPLACE_MASK_RST;
      cfg_r.max_payload  <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ID_MASK:      cfg_r.id_mask      <= cfg_data;
        REG_REPLACE_MASK: cfg_r.replace_mask <= cfg_data;
        REG_MAX_PAYLOAD:  cfg_r.max_payload  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = can_take;
  assign acc         = in_ch.valid && can_take;

  efd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_ch.data_byte),
    .buffer_end (in_ch.buffer_end),
    .cfg        (cfg_r),
    .n_res      (n_res),
    .res0       (res0),
    .res1       (res1)
  );

  efd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (acc),
    .n_res      (n_res),
    .res0       (res0),
    .res1       (res1),
    .can_take   (can_take),
    .head_valid (out_ch.valid),
    .head_ready (out_ch.ready),
    .head       (head)
  );

  assign out_ch.kind         = head.kind;
  assign out_ch.payload_byte = head.payload_byte;
  assign out_ch.event_id     = head.event_id;
  assign out_ch.replacement  = head.replacement;
  assign out_ch.source_id    = head.source_id;
  assign out_ch.payload_len  = head.payload_len;
  assign out_ch.consumed     = head.consumed;
  assign out_ch.error_code   = head.error_code;
  assign out_ch.run_end      = head.run_end;

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import efd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 10;

  typedef enum logic [2:0] {
    WANT_HDR_LO,
    WANT_HDR_HI,
    WANT_SOURCE,
    WANT_LENGTH,
    WANT_PAYLOAD,
    SKIP_REST
  } frame_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  efd_in_if  in_ch ();
  efd_out_if out_ch ();

  event_frame_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies
  logic [15:0] id_mask_q      = ID_MASK_RST;
  logic [15:0] replace_mask_q = REPLACE_MASK_RST;
  logic [7:0]  max_payload_q  = MAX_PAYLOAD_RST;

  // frame decoder state
  frame_phase_e fr_phase  = WANT_HDR_LO;
  logic [15:0]  fr_header = '0;
  logic [7:0]   fr_source = '0;
  logic [7:0]   fr_length = '0;
  logic [7:0]   fr_left   = '0;

  in_word_t word_q[$];
  res_t     expected_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_cycles    = 0;
  int quiet_cycles   = 0;
  int queued_words   = 0;
  int words_accepted = 0;
  int results_checked = 0;
  int byte_results   = 0;
  int done_results   = 0;
  int error_results  = 0;
  int err_cnt        = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t error_result(input logic [1:0] code);
    res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic res_t done_result();
    res_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.event_id = fr_header & id_mask_q;
    r.replacement = |(fr_header & replace_mask_q);
    r.source_id = fr_source;
    r.payload_len = fr_length;
    r.consumed = 9'(HeaderSize) + 9'(fr_length);
    return r;
  endfunction

  task automatic deframe_word(input logic [7:0] b, input logic last);
    res_t outs[$];
    res_t r;
    case (fr_phase)
      WANT_HDR_LO: begin
        fr_header = {8'h00, b};
        if (last) outs.insert(outs.size(), error_result(ERR_TRUNC_HEADER));
        else fr_phase = WANT_HDR_HI;
      end
      WANT_HDR_HI: begin
        fr_header[15:8] = b;
        fr_phase = last ? WANT_HDR_LO : WANT_SOURCE;
        if (last) outs.insert(outs.size(), error_result(ERR_TRUNC_HEADER));
      end
      WANT_SOURCE: begin
        fr_source = b;
        fr_phase = last ? WANT_HDR_LO : WANT_LENGTH;
        if (last) outs.insert(outs.size(), error_result(ERR_TRUNC_HEADER));
      end
      WANT_LENGTH: begin
        fr_length = b;
        if (b > max_payload_q) begin
          outs.insert(outs.size(), error_result(ERR_TOO_LARGE));
          fr_phase = last ? WANT_HDR_LO : SKIP_REST;
        end else if (b == 8'd0) begin
          outs.insert(outs.size(), done_result());
          fr_phase = last ? WANT_HDR_LO : SKIP_REST;
        end else if (last) begin
          outs.insert(outs.size(), error_result(ERR_TRUNC_PAYLOAD));
          fr_phase = WANT_HDR_LO;
        end else begin
          fr_left = b;
          fr_phase = WANT_PAYLOAD;
        end
      end
      WANT_PAYLOAD: begin
        r = '0;
        r.kind = KIND_BYTE;
        r.payload_byte = b;
        outs.insert(outs.size(), r);
        fr_left = fr_left - 8'd1;
        if (fr_left == 8'd0) begin
          outs.insert(outs.size(), done_result());
          fr_phase = last ? WANT_HDR_LO : SKIP_REST;
        end else if (last) begin
          outs.insert(outs.size(), error_result(ERR_TRUNC_PAYLOAD));
          fr_left = 8'd0;
          fr_phase = WANT_HDR_LO;
        end
      end
      default: begin
        fr_phase = last ? WANT_HDR_LO : SKIP_REST;
      end
    endcase
    if (outs.size() != 0) outs[outs.size() - 1].run_end = 1'b1;
    foreach (outs[i]) expected_results.insert(expected_results.size(), outs[i]);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, seen);
      err_cnt++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: kind %0d", out_ch.kind);
      err_cnt++;
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 16'(want.kind), 16'(out_ch.kind));
      check_field("payload_byte", 16'(want.payload_byte), 16'(out_ch.payload_byte));
      check_field("event_id", want.event_id, out_ch.event_id);
      check_field("replacement", 16'(want.replacement), 16'(out_ch.replacement));
      check_field("source_id", 16'(want.source_id), 16'(out_ch.source_id));
      check_field("payload_len", 16'(want.payload_len), 16'(out_ch.payload_len));
      check_field("consumed", 16'(want.consumed), 16'(out_ch.consumed));
      check_field("error_code", 16'(want.error_code), 16'(out_ch.error_code));
      check_field("run_end", 16'(want.run_end), 16'(out_ch.run_end));
      results_checked++;
      case (want.kind)
        KIND_BYTE: byte_results++;
        KIND_DONE: done_results++;
        default:   error_results++;
      endcase
    end
  endtask

  // word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_word(in_ch.data_byte, in_ch.buffer_end);
        words_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= word_q[0].data;
          in_ch.buffer_end <= word_q[0].last;
          void'(word_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, owns the receiver's ready and any long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_cycles = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic queue_word(input logic [7:0] b, input logic last);
    in_word_t w;
    w.data = b;
    w.last = last;
    word_q.insert(word_q.size(), w);
    queued_words++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ID_MASK:      id_mask_q = val;
      REG_REPLACE_MASK: replace_mask_q = val;
      REG_MAX_PAYLOAD:  max_payload_q = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_masks(input logic [15:0] id_m, input logic [15:0] rep_m,
                           input logic [7:0] max_len);
    write_reg(REG_ID_MASK, id_m);
    write_reg(REG_REPLACE_MASK, rep_m);
    write_reg(REG_MAX_PAYLOAD, {8'($urandom), max_len});
  endtask

  // the extra cycles cover words still inside the block that give no result
  task automatic wait_all_results();
    while (word_q.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_buffer();
    logic [7:0]  frame[$];
    logic [15:0] hdr;
    logic [7:0]  len;
    int          pick;
    int          n_pay;
    int          cut;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // noise
      repeat ($urandom_range(1, 6)) frame.insert(frame.size(), 8'($urandom));
    end else begin
      hdr = 16'($urandom);
      cut = $urandom_range(99);
      if (cut < 62) len = 8'($urandom_range(0, 6));
      else if (cut < 84) len = 8'($urandom_range(7, 40));
      else if (cut < 97 && max_payload_q != 8'hff)
        len = 8'($urandom_range(int'(max_payload_q) + 1, 255));
      else if (cut < 97) len = 8'($urandom_range(41, 80));
      else len = 8'hff;
      frame.insert(frame.size(), hdr[7:0]);
      frame.insert(frame.size(), hdr[15:8]);
      frame.insert(frame.size(), 8'($urandom));
      frame.insert(frame.size(), len);
      n_pay = (len > max_payload_q) ? $urandom_range(0, 3) : int'(len);
      repeat (n_pay) frame.insert(frame.size(), 8'($urandom));
      if (pick < 84) begin
        repeat ($urandom_range(0, 2)) frame.insert(frame.size(), 8'($urandom));
      end else begin
        cut = $urandom_range(1, frame.size() - 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end
    end
    foreach (frame[i]) queue_word(frame[i], i == frame.size() - 1);
  endtask

  task automatic queue_buffers(input int n_words);
    int start;
    start = queued_words;
    while (queued_words - start < n_words) queue_buffer();
  endtask

  initial begin
    int p;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_ID_MASK;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.buffer_end = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // zero length: completion on the length byte
    queue_word(8'h01, 0); queue_word(8'h80, 0); queue_word(8'hff, 0); queue_word(8'h00, 1);
    // two payload bytes, then a trailing word that is ignored
    queue_word(8'hff, 0); queue_word(8'hff, 0); queue_word(8'h00, 0); queue_word(8'h02, 0);
    queue_word(8'haa, 0); queue_word(8'h55, 0); queue_word(8'hc3, 1);
    // buffer ends on the source byte
    queue_word(8'h34, 0); queue_word(8'h56, 0); queue_word(8'h78, 1);
    // buffer ends inside the payload
    queue_word(8'h00, 0); queue_word(8'h00, 0); queue_word(8'h01, 0); queue_word(8'h03, 0);
    queue_word(8'h11, 0); queue_word(8'h22, 1);
    // header only, registers change before the length byte arrives
    queue_word(8'hab, 0); queue_word(8'hcd, 0); queue_word(8'hef, 0);
    wait_all_results();
    set_masks(16'hffff, 16'h0001, 8'h00);
    write_reg(REG_UNUSED, 16'($urandom));
    queue_word(8'h00, 1);
    // length above the limit on the buffer's final word
    queue_word(8'h00, 0); queue_word(8'h00, 0); queue_word(8'h00, 0); queue_word(8'hff, 1);
    wait_all_results();

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_masks(16'hffff, 16'h0000, 8'hff);
        end
        1: begin
          send_idle_pct = 85; recv_stall_pct = 0;
          set_masks(16'h0000, 16'hffff, 8'($urandom_range(4, 40)));
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 85;
          set_masks(16'($urandom), 16'($urandom), 8'($urandom_range(8, 255)));
        end
        default: begin
          send_idle_pct = 27; recv_stall_pct = 27;
          set_masks(ID_MASK_RST, REPLACE_MASK_RST, MAX_PAYLOAD_RST);
        end
      endcase
      // long receiver hold-off while words keep coming, so the input stalls
      if (p == 0 || p == 3) hold_requests++;
      queue_buffers(175);
      wait_all_results();
      queue_buffers(175);
      wait_all_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input words across four idle/stall mixes and six register settings",
             words_accepted);
    $display("checked %0d results: %0d payload bytes, %0d completions, %0d errors",
             results_checked, byte_results, done_results, error_results);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
